// ===== design/tiny_risc_instruction_executor_macros.svh =====
// Assertion macros used by the executor's back end.
// Depends on nothing; the using module must have signals named clock and reset.
`ifndef TINY_RISC_INSTRUCTION_EXECUTOR_MACROS_SVH
`define TINY_RISC_INSTRUCTION_EXECUTOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TRE_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TRE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/tre_pkg.sv =====
// Shared constants, operation codes and the decoded instruction type.
// Depends on nothing; the front end, register file, back end and top level import it.
package tre_pkg;

   localparam int MEM_WORDS_DEF  = 4096;
   localparam int PROG_DEPTH_DEF = 1024;
   localparam int REG_COUNT_DEF  = 16;

   localparam int XLEN        = 32;
   localparam int OP_W        = 3;
   localparam int REG_FIELD_W = 4;
   localparam int LEN_W       = 11;
   localparam int TARGET_W    = 10;

   // Depth of the queue between the decode front and the execute back.
   localparam int QUEUE_DEPTH = 2;

   localparam logic [OP_W-1:0] OP_ADDI = 3'd0;
   localparam logic [OP_W-1:0] OP_BEQ  = 3'd1;
   localparam logic [OP_W-1:0] OP_LW   = 3'd2;
   localparam logic [OP_W-1:0] OP_SW   = 3'd3;
   localparam logic [OP_W-1:0] OP_JALR = 3'd4;
   localparam logic [OP_W-1:0] OP_OUT  = 3'd5;
   localparam logic [OP_W-1:0] OP_HALT = 3'd6;

   // One instruction after decode. Source indexes that fall outside the
   // register file are already replaced by zero, and wr_en is only set
   // when the destination is a real, writable register.
   typedef struct packed {
      logic                   is_addi;
      logic                   is_beq;
      logic                   is_lw;
      logic                   is_sw;
      logic                   is_jalr;
      logic                   is_out;
      logic                   is_halt;
      logic                   wr_en;
      logic [REG_FIELD_W-1:0] rd;
      logic [REG_FIELD_W-1:0] rs1;
      logic [REG_FIELD_W-1:0] rs2;
      logic [XLEN-1:0]        imm;
      logic [TARGET_W-1:0]    target;
   } tre_item_type;

endpackage

// ===== design/tre_req_if.sv =====
// Instruction channel: valid/ready handshake with the decoded instruction fields.
// Depends on nothing.
interface tre_req_if;
   logic              valid;
   logic              ready;
   logic [2:0]        op;
   logic [3:0]        dest_reg;
   logic [3:0]        src1_reg;
   logic [3:0]        src2_reg;
   logic signed [31:0] immediate;
   logic [9:0]        branch_target;

   modport source (
      output valid, op, dest_reg, src1_reg, src2_reg, immediate, branch_target,
      input  ready
   );

   modport sink (
      input  valid, op, dest_reg, src1_reg, src2_reg, immediate, branch_target,
      output ready
   );
endinterface

// ===== design/tre_rsp_if.sv =====
// Result channel: valid/ready handshake with next pc, output value and done flag.
// Depends on nothing.
interface tre_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] next_pc;
   logic               out_valid;
   logic signed [31:0] out_value;
   logic               done_res;

   modport source (
      output valid, next_pc, out_valid, out_value, done_res,
      input  ready
   );

   modport sink (
      input  valid, next_pc, out_valid, out_value, done_res,
      output ready
   );
endinterface

// ===== design/tre_front.sv =====
// Front end: accepts instructions, decodes them and queues them for execution.
// Depends on tre_pkg and tre_req_if.
module tre_front #(
   parameter int REG_COUNT = tre_pkg::REG_COUNT_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   tre_req_if.sink              req_bus,
   input  logic                 hold_off,
   input  logic                 pop,
   output logic                 head_valid,
   output tre_pkg::tre_item_type head_item
);
   import tre_pkg::*;

   localparam int PtrW = $clog2(QUEUE_DEPTH);
   localparam int CntW = $clog2(QUEUE_DEPTH + 1);

   tre_item_type    entry_ff [QUEUE_DEPTH];
   tre_item_type    decoded;
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            push;

   // Decode the op into one flag per operation; code 7 decodes to a no-op.
   always_comb begin
      decoded        = '0;
      decoded.rd     = req_bus.dest_reg;
      decoded.rs1    = (32'(req_bus.src1_reg) < REG_COUNT) ? req_bus.src1_reg : '0;
      decoded.rs2    = (32'(req_bus.src2_reg) < REG_COUNT) ? req_bus.src2_reg : '0;
      decoded.imm    = req_bus.immediate;
      decoded.target = req_bus.branch_target;
      unique case (req_bus.op)
         OP_ADDI: decoded.is_addi = 1'b1;
         OP_BEQ:  decoded.is_beq  = 1'b1;
         OP_LW:   decoded.is_lw   = 1'b1;
         OP_SW:   decoded.is_sw   = 1'b1;
         OP_JALR: decoded.is_jalr = 1'b1;
         OP_OUT:  decoded.is_out  = 1'b1;
         OP_HALT: decoded.is_halt = 1'b1;
         default: ;
      endcase
      decoded.wr_en = (decoded.is_addi || decoded.is_lw || decoded.is_jalr) &&
                      (req_bus.dest_reg != '0) && (32'(req_bus.dest_reg) < REG_COUNT);
   end

   assign req_bus.ready = (count_ff != CntW'(QUEUE_DEPTH)) && !hold_off;
   assign push          = req_bus.valid && req_bus.ready;
   assign head_valid    = (count_ff != '0);
   assign head_item     = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

// ===== design/tre_regfile.sv =====
// Register file: two registered read ports with write-first bypass, one write port.
// Depends on tre_pkg. Entries never written since reset read as zero.
module tre_regfile #(
   parameter int REG_COUNT = tre_pkg::REG_COUNT_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         rd_en,
   input  logic [$clog2(REG_COUNT)-1:0] rd_addr1,
   input  logic [$clog2(REG_COUNT)-1:0] rd_addr2,
   output logic [tre_pkg::XLEN-1:0]     rd_data1_ff,
   output logic [tre_pkg::XLEN-1:0]     rd_data2_ff,
   input  logic                         wr_en,
   input  logic [$clog2(REG_COUNT)-1:0] wr_addr,
   input  logic [tre_pkg::XLEN-1:0]     wr_data
);
   import tre_pkg::*;

   logic [XLEN-1:0]      regs [REG_COUNT];
   logic [REG_COUNT-1:0] filled_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         filled_ff <= '0;
      end else if (wr_en) begin
         filled_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         regs[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr1)) begin
            rd_data1_ff <= wr_data;
         end else if (filled_ff[rd_addr1]) begin
            rd_data1_ff <= regs[rd_addr1];
         end else begin
            rd_data1_ff <= '0;
         end
         if (wr_en && (wr_addr == rd_addr2)) begin
            rd_data2_ff <= wr_data;
         end else if (filled_ff[rd_addr2]) begin
            rd_data2_ff <= regs[rd_addr2];
         end else begin
            rd_data2_ff <= '0;
         end
      end
   end

endmodule

// ===== design/tre_back.sv =====
// Back end: operand read, execute stage with pc and data memory, result register.
// Depends on tre_pkg, tre_rsp_if, tre_regfile and the executor's assertion macros.
`include "tiny_risc_instruction_executor_macros.svh"

module tre_back #(
   parameter int MEM_WORDS  = tre_pkg::MEM_WORDS_DEF,
   parameter int PROG_DEPTH = tre_pkg::PROG_DEPTH_DEF,
   parameter int REG_COUNT  = tre_pkg::REG_COUNT_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      head_valid,
   input  tre_pkg::tre_item_type     head_item,
   output logic                      pop,
   output logic                      clearing,
   input  logic [tre_pkg::LEN_W-1:0] prog_len,
   tre_rsp_if.source                 rsp_bus
);
   import tre_pkg::*;

   localparam int AddrW   = $clog2(MEM_WORDS);
   localparam int RegIdxW = $clog2(REG_COUNT);
   localparam logic [XLEN-1:0] ProgDepth = XLEN'(PROG_DEPTH);

   // Pipeline control.
   logic adv;
   logic fire;
   logic execute;

   // Execute stage.
   logic            ex_valid_ff;
   tre_item_type    ex_item_ff;
   logic [XLEN-1:0] rf_data1, rf_data2;
   logic [XLEN-1:0] op1, op2;
   logic [XLEN-1:0] eff_len;
   logic [XLEN-1:0] sum;
   logic [XLEN-1:0] pc_plus1;
   logic [XLEN-1:0] next_calc;
   logic            pc_inside;
   logic            next_inside;
   logic            ignore;
   logic            ex_done;
   logic [AddrW-1:0] mem_addr;

   // Architectural state.
   logic [XLEN-1:0] pc_ff, pc_in;
   logic            halted_ff, halted_in;

   // Writeback / result stage.
   logic               wb_valid_ff;
   logic               wb_we_ff;
   logic [RegIdxW-1:0] wb_rd_ff;
   logic [XLEN-1:0]    wb_data_ff;
   logic               wb_load_ff;
   logic [XLEN-1:0]    wb_value;
   logic               wb_write;
   logic [XLEN-1:0]    rsp_next_pc_ff;
   logic               rsp_out_valid_ff;
   logic [XLEN-1:0]    rsp_out_value_ff;
   logic               rsp_done_ff;

   // Data memory and its clearing pass.
   logic [XLEN-1:0]  dmem [MEM_WORDS];
   logic [XLEN-1:0]  dmem_rdata_ff;
   logic             clearing_ff;
   logic [AddrW-1:0] clr_addr_ff, clr_addr_in;

   assign adv      = !wb_valid_ff || rsp_bus.ready;
   assign pop      = adv && head_valid && !clearing_ff;
   assign clearing = clearing_ff;

   tre_regfile #(
      .REG_COUNT (REG_COUNT)
   ) u_regfile (
      .clock       (clock),
      .reset       (reset),
      .rd_en       (pop),
      .rd_addr1    (RegIdxW'(head_item.rs1)),
      .rd_addr2    (RegIdxW'(head_item.rs2)),
      .rd_data1_ff (rf_data1),
      .rd_data2_ff (rf_data2),
      .wr_en       (wb_write),
      .wr_addr     (wb_rd_ff),
      .wr_data     (wb_value)
   );

   // The instruction in writeback may target an operand already read from the register file.
   assign wb_write = wb_valid_ff && wb_we_ff;
   assign wb_value = wb_load_ff ? dmem_rdata_ff : wb_data_ff;
   assign op1 = (wb_write && (wb_rd_ff == RegIdxW'(ex_item_ff.rs1))) ? wb_value : rf_data1;
   assign op2 = (wb_write && (wb_rd_ff == RegIdxW'(ex_item_ff.rs2))) ? wb_value : rf_data2;

   always_comb begin
      eff_len   = (XLEN'(prog_len) < ProgDepth) ? XLEN'(prog_len) : ProgDepth;
      pc_inside = !pc_ff[XLEN-1] && (pc_ff < eff_len);
      ignore    = halted_ff || !pc_inside;
      sum       = op1 + ex_item_ff.imm;
      pc_plus1  = pc_ff + 1'b1;
      if (ex_item_ff.is_beq && (op1 == op2)) begin
         next_calc = XLEN'(ex_item_ff.target);
      end else if (ex_item_ff.is_jalr) begin
         next_calc = sum;
      end else if (ex_item_ff.is_halt) begin
         next_calc = eff_len;
      end else begin
         next_calc = pc_plus1;
      end
      next_inside = !next_calc[XLEN-1] && (next_calc < eff_len);
      ex_done     = ignore || ex_item_ff.is_halt || !next_inside;
   end

   assign mem_addr = sum[AddrW-1:0];
   assign fire     = adv && ex_valid_ff;
   assign execute  = fire && !ignore;

   always_comb begin
      pc_in     = pc_ff;
      halted_in = halted_ff;
      if (fire) begin
         halted_in = ex_done;
         if (!ignore) begin
            pc_in = next_calc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ex_valid_ff <= 1'b0;
         wb_valid_ff <= 1'b0;
         pc_ff       <= '0;
         halted_ff   <= 1'b0;
      end else begin
         if (adv) begin
            ex_valid_ff <= pop;
            wb_valid_ff <= ex_valid_ff;
         end
         pc_ff     <= pc_in;
         halted_ff <= halted_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         ex_item_ff <= head_item;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         wb_we_ff         <= !ignore && ex_item_ff.wr_en;
         wb_rd_ff         <= RegIdxW'(ex_item_ff.rd);
         wb_data_ff       <= ex_item_ff.is_jalr ? pc_plus1 : sum;
         wb_load_ff       <= ex_item_ff.is_lw;
         rsp_next_pc_ff   <= ignore ? pc_ff : next_calc;
         rsp_out_valid_ff <= !ignore && ex_item_ff.is_out;
         rsp_out_value_ff <= (!ignore && ex_item_ff.is_out) ? op1 : '0;
         rsp_done_ff      <= ex_done;
      end
   end

   // The memory is swept to zero after reset, one word per cycle.
   always_comb begin
      clr_addr_in = clr_addr_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clearing_ff) begin
         clr_addr_ff <= clr_addr_in;
         if (clr_addr_ff == AddrW'(MEM_WORDS - 1)) begin
            clearing_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         dmem[clr_addr_ff] <= '0;
      end else if (execute && ex_item_ff.is_sw) begin
         dmem[mem_addr] <= op2;
      end
   end

   always_ff @(posedge clock) begin
      if (execute && ex_item_ff.is_lw) begin
         dmem_rdata_ff <= dmem[mem_addr];
      end
   end

   assign rsp_bus.valid     = wb_valid_ff;
   assign rsp_bus.next_pc   = rsp_next_pc_ff;
   assign rsp_bus.out_valid = rsp_out_valid_ff;
   assign rsp_bus.out_value = rsp_out_value_ff;
   assign rsp_bus.done_res  = rsp_done_ff;

   `TRE_ASSERT_NOW(a_empty_while_clearing, clearing_ff, !ex_valid_ff && !wb_valid_ff, "pipeline busy during memory clear")
   `TRE_ASSERT_NEXT(a_halt_sticky, halted_ff, halted_ff, "halt cleared without reset")
   `TRE_ASSERT_NEXT(a_pc_only_on_execute, !(adv && ex_valid_ff), $stable(pc_ff), "pc moved with no instruction executing")
   `TRE_ASSERT_NOW(a_no_x0_write, wb_write, wb_rd_ff != '0, "register x0 written")

endmodule

// ===== design/tiny_risc_instruction_executor.sv =====
// Top level of the tiny RISC instruction executor: front end, queue and back end.
// Depends on tre_pkg, tre_req_if, tre_rsp_if, tre_front and tre_back.
//
//   Channel   Direction  Handshake      Carries
//   req_bus   in         valid/ready    op, dest_reg, src1_reg, src2_reg, immediate,
//                                       branch_target
//   rsp_bus   out        valid/ready    next_pc, out_valid, out_value, done_res
//   csr_*     in         write enable   program_length (11 bits)
//
// One instruction completes per cycle while rsp_bus takes every result. A transfer on
// req_bus passes the decode queue, then operand read and execute, to the result register.
// The rate is set by the execute stage, which updates the pc, reads or writes the
// single-port data memory and resolves the halt for each instruction.
// After reset the data memory is cleared word by word, all MEM_WORDS (4096 by default);
// req_bus.ready stays low until it is done, but csr writes are taken.
// A stalled rsp_bus holds the result; the queue keeps taking transfers until full.
module tiny_risc_instruction_executor #(
   parameter int MEM_WORDS  = tre_pkg::MEM_WORDS_DEF,
   parameter int PROG_DEPTH = tre_pkg::PROG_DEPTH_DEF,
   parameter int REG_COUNT  = tre_pkg::REG_COUNT_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   tre_req_if.sink                   req_bus,
   tre_rsp_if.source                 rsp_bus,
   input  logic                      csr_write_en,
   input  logic [tre_pkg::LEN_W-1:0] csr_write_data
);
   import tre_pkg::*;

   // Program length register. The user must see that it is only written while the block
   // is idle (the block does not enforce it), so the execute stage may read it directly.
   logic [LEN_W-1:0] prog_len_ff;

   // Queue head as seen by the back end, and the pop that removes it.
   logic         head_valid;
   tre_item_type head_item;
   logic         pop;

   // The back end raises this while it sweeps the data memory.
   logic clearing;

   always_ff @(posedge clock) begin
      if (reset) begin
         prog_len_ff <= '0;
      end else if (csr_write_en) begin
         prog_len_ff <= csr_write_data;
      end
   end

   // Front end: takes transfers, decodes the op and queues the instruction.
   tre_front #(
      .REG_COUNT (REG_COUNT)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .hold_off   (clearing),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   // Back end: reads operands, executes against pc, registers and memory,
   // and holds the result until rsp_bus takes it.
   tre_back #(
      .MEM_WORDS  (MEM_WORDS),
      .PROG_DEPTH (PROG_DEPTH),
      .REG_COUNT  (REG_COUNT)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_item  (head_item),
      .pop        (pop),
      .clearing   (clearing),
      .prog_len   (prog_len_ff),
      .rsp_bus    (rsp_bus)
   );

endmodule

// ===== test/tiny_risc_instruction_executor_tb.sv =====
// Self-checking testbench for the tiny RISC instruction executor.
// Depends on tre_pkg, tre_req_if, tre_rsp_if and the executor RTL; an internal
// architectural model predicts every result and a monitor checks it field by field.
`timescale 1ns / 100ps

module tiny_risc_instruction_executor_tb;
   import tre_pkg::*;

   localparam int CLK_PERIOD     = 20;
   localparam int MEM_WORDS      = MEM_WORDS_DEF;
   localparam int MEM_AW         = $clog2(MEM_WORDS);
   localparam int PROG_DEPTH     = PROG_DEPTH_DEF;
   localparam int REG_COUNT      = REG_COUNT_DEF;
   localparam int CHOKE_CYCLES   = 80;
   localparam int FLUSH_CYCLES   = 8;
   localparam int TIMEOUT_CYCLES = 600_000;

   // Op code 7 has no name in the package; the block treats it as a no-op.
   localparam logic [OP_W-1:0] OP_SPARE = 3'd7;

   // The ways the single run may end. Only reset clears a halt, and reset is
   // applied once, so each run picks one of them at random.
   typedef enum {
      END_HALT,
      END_JUMP_NEGATIVE,
      END_FALL_OFF,
      END_EMPTY_PROGRAM
   } finish_kind_type;

   typedef struct packed {
      logic [OP_W-1:0]        op;
      logic [REG_FIELD_W-1:0] rd;
      logic [REG_FIELD_W-1:0] rs1;
      logic [REG_FIELD_W-1:0] rs2;
      logic [XLEN-1:0]        imm;
      logic [TARGET_W-1:0]    target;
   } instr_type;

   typedef struct packed {
      logic [XLEN-1:0] next_pc;
      logic            out_valid;
      logic [XLEN-1:0] out_value;
      logic            done;
   } outcome_type;

   // An instruction together with the outcome the architectural model gave it.
   typedef struct packed {
      instr_type   ins;
      outcome_type want;
   } planned_type;

   logic                clock;
   logic                reset;
   logic                csr_write_en;
   logic [LEN_W-1:0]    csr_write_data;

   tre_req_if req_bus ();
   tre_rsp_if rsp_bus ();

   tiny_risc_instruction_executor u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_bus        (req_bus),
      .rsp_bus        (rsp_bus),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   // Architectural state of the executor as the testbench sees it.
   logic [XLEN-1:0]  arch_pc;
   logic [XLEN-1:0]  arch_regs [REG_COUNT];
   logic [XLEN-1:0]  arch_mem [MEM_WORDS];
   logic             arch_halted;
   logic [LEN_W-1:0] prog_len;

   planned_type instr_queue[$];   // instructions waiting for the driver
   outcome_type result_queue[$];  // outcomes of transferred instructions, oldest first
   outcome_type on_bus;           // outcome of the instruction now offered on req_bus
   outcome_type got_want;
   logic        req_taken;
   int unsigned issued;
   int unsigned retired;
   int unsigned errors;
   int unsigned send_gap;
   int unsigned rsp_stall;
   int unsigned choke_asked;
   int unsigned choke_served;
   bit          no_idle;

   initial begin
      clock = 1'b0;
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   // A generous upper bound on the run; a correct run finishes far sooner.
   initial begin
      #(TIMEOUT_CYCLES * CLK_PERIOD);
      $display("tiny_risc_instruction_executor test failed");
      $finish;
   end

   // ---------------------------------------------------------------------------
   // Architectural model
   // ---------------------------------------------------------------------------

   function automatic logic [XLEN-1:0] eff_len();
      return (prog_len < PROG_DEPTH) ? 32'(prog_len) : 32'(PROG_DEPTH);
   endfunction

   // A pc with its top bit set is negative and therefore outside the program.
   function automatic bit pc_inside(logic [XLEN-1:0] pc);
      return !pc[XLEN-1] && (pc < eff_len());
   endfunction

   // Register x0 is hard-wired to zero.
   function automatic logic [XLEN-1:0] reg_val(logic [REG_FIELD_W-1:0] idx);
      return (idx == 0) ? '0 : arch_regs[idx];
   endfunction

   // Works out the result of one instruction at the current pc. With commit
   // cleared it only looks, so the stimulus can try out candidates; with commit
   // set it also updates the architectural state.
   function automatic outcome_type execute(instr_type ins, bit commit);
      outcome_type     r;
      logic [XLEN-1:0] nxt;
      logic [XLEN-1:0] addr;

      r.next_pc   = arch_pc;
      r.out_valid = 1'b0;
      r.out_value = '0;
      r.done      = 1'b1;
      // A halted block, or one whose pc is already outside the program,
      // ignores the instruction and reports its pc unchanged.
      if (arch_halted || !pc_inside(arch_pc)) begin
         if (commit)
            arch_halted = 1'b1;
         return r;
      end

      r.done = 1'b0;
      nxt    = arch_pc + 1;
      case (ins.op)
         OP_ADDI: begin
            if (commit && ins.rd != 0)
               arch_regs[ins.rd] = reg_val(ins.rs1) + ins.imm;
         end
         OP_BEQ: begin
            if (reg_val(ins.rs1) == reg_val(ins.rs2))
               nxt = 32'(ins.target);
         end
         OP_LW: begin
            addr = reg_val(ins.rs1) + ins.imm;
            if (commit && ins.rd != 0)
               arch_regs[ins.rd] = arch_mem[MEM_AW'(addr % MEM_WORDS)];
         end
         OP_SW: begin
            addr = reg_val(ins.rs1) + ins.imm;
            if (commit)
               arch_mem[MEM_AW'(addr % MEM_WORDS)] = reg_val(ins.rs2);
         end
         OP_JALR: begin
            // The jump source is read before the link register is written.
            nxt = reg_val(ins.rs1) + ins.imm;
            if (commit && ins.rd != 0)
               arch_regs[ins.rd] = arch_pc + 1;
         end
         OP_OUT: begin
            r.out_valid = 1'b1;
            r.out_value = reg_val(ins.rs1);
         end
         OP_HALT: begin
            nxt    = eff_len();
            r.done = 1'b1;
         end
         default: ;
      endcase

      if (!pc_inside(nxt))
         r.done = 1'b1;
      r.next_pc = nxt;
      if (commit) begin
         arch_pc = nxt;
         if (r.done)
            arch_halted = 1'b1;
      end
      return r;
   endfunction

   // ---------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------

   function automatic instr_type mk(logic [OP_W-1:0] op, logic [REG_FIELD_W-1:0] rd,
                                    logic [REG_FIELD_W-1:0] rs1,
                                    logic [REG_FIELD_W-1:0] rs2,
                                    logic [XLEN-1:0] imm, logic [TARGET_W-1:0] target);
      instr_type ins;

      ins.op     = op;
      ins.rd     = rd;
      ins.rs1    = rs1;
      ins.rs2    = rs2;
      ins.imm    = imm;
      ins.target = target;
      return ins;
   endfunction

   function automatic instr_type raw_instr();
      return mk(OP_W'($urandom_range(0, 7)), REG_FIELD_W'($urandom_range(0, 15)),
                REG_FIELD_W'($urandom_range(0, 15)), REG_FIELD_W'($urandom_range(0, 15)),
                $urandom, TARGET_W'($urandom_range(0, 1023)));
   endfunction

   // A random instruction that keeps the program running. The operands are
   // steered from the current architectural state so that loads and stores
   // hit a small window often, jumps land inside the program and branches are
   // often taken. A candidate that would end the run is thrown away; if none
   // survives, an always-taken branch back into the program is used.
   function automatic instr_type random_instr();
      instr_type   ins;
      outcome_type trial;
      int unsigned pick;

      for (int attempt = 0; attempt < 20; attempt++) begin
         ins  = raw_instr();
         pick = $urandom_range(0, 99);
         if (pick < 25)
            ins.op = OP_ADDI;
         else if (pick < 40)
            ins.op = OP_BEQ;
         else if (pick < 55)
            ins.op = OP_LW;
         else if (pick < 70)
            ins.op = OP_SW;
         else if (pick < 80)
            ins.op = OP_JALR;
         else if (pick < 95)
            ins.op = OP_OUT;
         else
            ins.op = OP_SPARE;

         case (ins.op)
            OP_ADDI: begin
               if ($urandom_range(0, 9) == 0)
                  ins.imm = '0;
               else if ($urandom_range(0, 1) == 0)
                  ins.imm = $urandom_range(0, 32) - 16;
            end
            OP_BEQ: begin
               if ($urandom_range(0, 9) < 4)
                  ins.rs2 = ins.rs1;
               ins.target = TARGET_W'($urandom_range(0, eff_len() - 1));
            end
            OP_LW, OP_SW: begin
               if ($urandom_range(0, 9) < 6)
                  ins.imm = $urandom_range(0, 63) + ($urandom_range(0, 7) << 12)
                            - reg_val(ins.rs1);
            end
            OP_JALR: begin
               ins.imm = $urandom_range(0, eff_len() - 1) - reg_val(ins.rs1);
            end
            default: ;
         endcase

         trial = execute(ins, 1'b0);
         if (!trial.done)
            return ins;
      end
      return mk(OP_BEQ, ins.rd, 0, 0, ins.imm, TARGET_W'($urandom_range(0, eff_len() - 1)));
   endfunction

   // Most gaps are short, a few are long.
   function automatic int unsigned pick_gap();
      int unsigned r;

      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 88)
         return $urandom_range(1, 3);
      if (r < 97)
         return $urandom_range(4, 12);
      return $urandom_range(13, 40);
   endfunction

   task automatic issue(instr_type ins);
      planned_type job;

      job.ins  = ins;
      job.want = execute(ins, 1'b1);
      instr_queue.push_back(job);
      issued++;
   endtask

   // The length register is only written once every issued instruction has
   // returned its result, so the block is idle at the write.
   task automatic write_length(logic [LEN_W-1:0] len);
      while (issued != retired)
         @(negedge clock);
      @(negedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= len;
      @(negedge clock);
      csr_write_en   <= 1'b0;
      prog_len = len;
   endtask

   function automatic void check_field(string name, logic [XLEN-1:0] want,
                                       logic [XLEN-1:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%08h, got 0x%08h", name, want, got);
         errors++;
      end
   endfunction

   // ---------------------------------------------------------------------------
   // Instruction driver: offers one instruction at a time, changing inputs at
   // the falling edge. A new instruction or a gap starts only after the
   // previous one was transferred.
   // ---------------------------------------------------------------------------
   always @(negedge clock) begin
      planned_type job;

      if (!reset && (!req_bus.valid || req_taken)) begin
         if (send_gap > 0) begin
            send_gap--;
            req_bus.valid <= 1'b0;
         end else if (instr_queue.size() > 0) begin
            job = instr_queue.pop_front();
            req_bus.op            <= job.ins.op;
            req_bus.dest_reg      <= job.ins.rd;
            req_bus.src1_reg      <= job.ins.rs1;
            req_bus.src2_reg      <= job.ins.rs2;
            req_bus.immediate     <= job.ins.imm;
            req_bus.branch_target <= job.ins.target;
            req_bus.valid         <= 1'b1;
            on_bus   = job.want;
            send_gap = no_idle ? 0 : pick_gap();
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Result receiver: random stalls, plus a long hold-off whenever the stimulus
   // asks for one, so that the internal queue fills and req_bus.ready drops.
   // ---------------------------------------------------------------------------
   always @(negedge clock) begin
      if (choke_served != choke_asked) begin
         choke_served = choke_asked;
         rsp_stall    = CHOKE_CYCLES;
      end
      if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
         if (!no_idle)
            rsp_stall = pick_gap();
      end
   end

   // ---------------------------------------------------------------------------
   // Monitor: at each rising edge, a transfer on req_bus queues the outcome of
   // that instruction, and a transfer on rsp_bus is checked against the oldest
   // queued outcome.
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      req_taken <= !reset && req_bus.valid && req_bus.ready;
      if (!reset && req_bus.valid && req_bus.ready)
         result_queue.push_back(on_bus);
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (result_queue.size() == 0) begin
            $error("result with no instruction outstanding: next_pc 0x%08h",
                   rsp_bus.next_pc);
            errors++;
         end else begin
            got_want = result_queue.pop_front();
            check_field("next_pc", got_want.next_pc, rsp_bus.next_pc);
            check_field("out_valid", 32'(got_want.out_valid), 32'(rsp_bus.out_valid));
            check_field("out_value", got_want.out_value, rsp_bus.out_value);
            check_field("done_res", 32'(got_want.done), 32'(rsp_bus.done_res));
            retired++;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------------
   initial begin
      int unsigned     phase_lengths [8];
      int unsigned     item_count;
      logic [XLEN-1:0] new_eff;
      logic [XLEN-1:0] jump_lim;
      finish_kind_type how;

      // Every input is known from time zero.
      reset                 = 1'b1;
      csr_write_en          = 1'b0;
      csr_write_data        = '0;
      req_bus.valid         = 1'b0;
      req_bus.op            = OP_ADDI;
      req_bus.dest_reg      = '0;
      req_bus.src1_reg      = '0;
      req_bus.src2_reg      = '0;
      req_bus.immediate     = '0;
      req_bus.branch_target = '0;
      rsp_bus.ready         = 1'b0;
      req_taken             = 1'b0;
      issued                = 0;
      retired               = 0;
      errors                = 0;
      send_gap              = 0;
      rsp_stall             = 0;
      choke_asked           = 0;
      choke_served          = 0;
      no_idle               = 1'b0;
      arch_pc               = '0;
      arch_halted           = 1'b0;
      prog_len              = '0;
      foreach (arch_regs[k])
         arch_regs[k] = '0;
      foreach (arch_mem[k])
         arch_mem[k] = '0;

      phase_lengths = '{1024, 1, 2, 37, 1000, 1025, 300, 2047};

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // The length starts at zero; write it at both extremes. These writes
      // land while the block is still clearing its data memory.
      write_length('0);
      write_length(11'd2047);

      // Directed part: extreme immediates, wrap-around, writes to x0, address
      // wrap for negative and very large bases, a read of a never-written word,
      // a branch taken to the last slot and one not taken, a jump-and-link whose
      // source is also its destination, and the spare op code.
      issue(mk(OP_ADDI, 1, 0, 0, 32'h7FFF_FFFF, 0));
      issue(mk(OP_ADDI, 2, 0, 0, 32'h8000_0000, 0));
      issue(mk(OP_ADDI, 3, 1, 0, 32'd1, 0));
      issue(mk(OP_ADDI, 0, 1, 0, 32'd5, 0));
      issue(mk(OP_OUT, 0, 0, 0, 0, 0));
      issue(mk(OP_OUT, 0, 3, 0, 0, 0));
      issue(mk(OP_SW, 0, 0, 1, 32'hFFFF_FFFF, 0));
      issue(mk(OP_LW, 4, 0, 0, 32'hFFFF_FFFF, 0));
      issue(mk(OP_SW, 0, 2, 2, 32'd5, 0));
      issue(mk(OP_LW, 5, 0, 0, 32'd5, 0));
      issue(mk(OP_LW, 6, 15, 0, 32'd100, 0));
      issue(mk(OP_BEQ, 0, 3, 5, 0, 10'd1023));
      issue(mk(OP_JALR, 7, 0, 0, 32'd12, 0));
      issue(mk(OP_BEQ, 0, 1, 2, 0, 0));
      issue(mk(OP_SPARE, 15, 15, 15, 32'hFFFF_FFFF, 10'd1023));
      issue(mk(OP_ADDI, 9, 0, 0, 32'd20, 0));
      issue(mk(OP_JALR, 9, 9, 0, 32'd5, 0));
      issue(mk(OP_OUT, 0, 9, 0, 0, 0));
      issue(mk(OP_OUT, 0, 7, 0, 0, 0));
      issue(mk(OP_ADDI, 15, 15, 0, 32'hFFFF_FFFF, 0));
      issue(mk(OP_OUT, 0, 15, 0, 0, 0));
      issue(mk(OP_BEQ, 0, 0, 0, 0, 0));
      issue(mk(OP_JALR, 0, 15, 0, 32'd1, 0));
      issue(mk(OP_SW, 0, 15, 15, 0, 0));
      issue(mk(OP_LW, 8, 0, 0, 32'd4095, 0));

      repeat (300) issue(random_instr());

      // Each phase first branches to an address that is inside both the old
      // and the new program, so the length can change without ending the run.
      for (int p = 0; p < 8; p++) begin
         new_eff  = (phase_lengths[p] < PROG_DEPTH) ? phase_lengths[p] : PROG_DEPTH;
         jump_lim = (eff_len() < new_eff) ? eff_len() : new_eff;
         issue(mk(OP_BEQ, 0, 0, 0, $urandom, TARGET_W'($urandom_range(0, jump_lim - 1))));
         write_length(LEN_W'(phase_lengths[p]));
         no_idle = (p == 3 || p == 6);
         if (p == 4 || p == 6)
            choke_asked++;
         item_count = (phase_lengths[p] < 8) ? 15 : 250;
         repeat (item_count) issue(random_instr());
      end
      no_idle = 1'b0;

      // End the program in one of its possible ways, then keep sending: every
      // later instruction must be ignored, even after the length is restored.
      how = finish_kind_type'($urandom_range(0, 3));
      case (how)
         END_HALT: begin
            issue(mk(OP_HALT, REG_FIELD_W'($urandom_range(0, 15)),
                     REG_FIELD_W'($urandom_range(0, 15)),
                     REG_FIELD_W'($urandom_range(0, 15)), $urandom,
                     TARGET_W'($urandom_range(0, 1023))));
         end
         END_JUMP_NEGATIVE: begin
            issue(mk(OP_JALR, REG_FIELD_W'($urandom_range(0, 15)), 0, 0,
                     {1'b1, 31'($urandom)}, 0));
         end
         END_FALL_OFF: begin
            issue(mk(OP_BEQ, 0, 0, 0, 0, TARGET_W'(eff_len() - 1)));
            issue(mk(OP_OUT, 0, REG_FIELD_W'($urandom_range(0, 15)), 0, 0, 0));
         end
         END_EMPTY_PROGRAM: begin
            write_length('0);
            issue(raw_instr());
         end
         default: ;
      endcase
      repeat (6) issue(raw_instr());
      write_length(11'd2047);
      repeat (6) issue(raw_instr());

      while (issued != retired)
         @(negedge clock);
      // Leave room for any stray result to show up before the verdict.
      repeat (FLUSH_CYCLES) @(negedge clock);

      if (errors == 0)
         $display("tiny_risc_instruction_executor test passed");
      else
         $display("tiny_risc_instruction_executor test failed");
      $finish;
   end

endmodule
